// ===== hw/rtl/scpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scpm_pkg;

   // Command line framing characters
   localparam logic [7:0] CHAR_COLON   = 8'h3a;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_ENABLE  = 8'h45;   // 'E'
   localparam logic [7:0] CHAR_OK      = 8'h4f;   // 'O'

   localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

   // Item kinds on the input channel
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Front-to-back queue sizing
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QUEUE_PTR_WIDTH-1:0] QUEUE_LAST_SLOT = QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1);

   typedef enum logic [2:0] {
      CLS_TICK,
      CLS_DIGIT,
      CLS_COLON,
      CLS_NEWLINE,
      CLS_OTHER
   } item_class_type;

   typedef enum logic [1:0] {
      PHASE_CMD   = 2'd0,
      PHASE_IO    = 2'd1,
      PHASE_VALUE = 2'd2
   } parse_phase_type;

   typedef enum logic [1:0] {
      LINK_NEVER = 2'd0,
      LINK_UP    = 2'd1,
      LINK_LOST  = 2'd2
   } link_state_type;

   // One classified transaction as it travels from front to back
   typedef struct packed {
      item_class_type cls;
      logic [7:0]     rx_byte;
   } queue_entry_type;

   // Queue status seen by the front, the back and the top level
   typedef struct packed {
      logic                         not_empty;
      logic                         full;
      logic [QUEUE_COUNT_WIDTH-1:0] count;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/serial_command_parser_link_monitor_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/stall    | req_kind, req_rx_byte
// rsp     | out       | rsp_valid/stall    | cmd_valid, cmd_char, io_number, cmd_value,
//         |           |                    | link_state, resend_request
// csr     | in/out    | psel/penable/pready| timeout_ms at byte address 0
//
// One transaction per cycle sustained while rsp_stall is low; each accepted transaction is
// written into the queue, then one execute step loads the output register, where the
// result is offered.
// The digit accumulate and watchdog compare in the back end are combinational.
// Synchronous active-high reset clears parser, watchdog and queue; timeout returns to 10000.
// A stalled result holds the back end; the queue absorbs two transactions before req_stall.
module serial_command_parser_link_monitor_core
   import scpm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_cmd_valid,
   output logic [7:0]       rsp_cmd_char,
   output logic [15:0]      rsp_io_number,
   output logic [15:0]      rsp_cmd_value,
   output logic [1:0]       rsp_link_state,
   output logic             rsp_resend_request,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam logic REG_TIMEOUT = 1'b0;

   logic [15:0]      timeout_ff, timeout_in;
   logic             csr_write;
   logic             push, pop;
   queue_entry_type  push_entry, head;
   queue_status_type q_status;

   // Register file
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT);
   assign timeout_in = csr_write ? pwdata[15:0] : timeout_ff;
   assign prdata    = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   scpm_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_kind    (req_kind),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   scpm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   scpm_back u_back (
      .clock              (clock),
      .reset              (reset),
      .timeout_ms         (timeout_ff),
      .q_status           (q_status),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cmd_valid      (rsp_cmd_valid),
      .rsp_cmd_char       (rsp_cmd_char),
      .rsp_io_number      (rsp_io_number),
      .rsp_cmd_value      (rsp_cmd_value),
      .rsp_link_state     (rsp_link_state),
      .rsp_resend_request (rsp_resend_request)
   );

   // Queue occupancy never exceeds its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QUEUE_COUNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count out of range");

   // A push without a pop grows the queue by one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=>
         (q_status.count == $past(q_status.count) + QUEUE_COUNT_WIDTH'(1)))
      else $error("queue did not grow on push");

   // A pop always finds an entry
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.not_empty)
      else $error("pop from empty queue");

   // A resend request comes only with a completed 'E' that reconnects the link
   a_resend_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_resend_request) |->
         (rsp_cmd_valid && rsp_cmd_char == CHAR_ENABLE && rsp_link_state == LINK_UP))
      else $error("resend request without an E command");

endmodule

`default_nettype wire

// ===== hw/rtl/scpm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scpm_front
   import scpm_pkg::*;
(
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_kind,
   input  wire logic [7:0]       req_rx_byte,
   input  wire queue_status_type q_status,
   output logic                  push,
   output queue_entry_type       push_entry
);

   // Stall only on a full queue, so stall follows registered state alone
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // Classify the transaction for the back end
   always_comb begin
      push_entry.rx_byte = req_rx_byte;
      if (req_kind == KIND_TICK) begin
         push_entry.cls = CLS_TICK;
      end else if (req_rx_byte >= CHAR_ZERO && req_rx_byte <= CHAR_NINE) begin
         push_entry.cls = CLS_DIGIT;
      end else if (req_rx_byte == CHAR_COLON) begin
         push_entry.cls = CLS_COLON;
      end else if (req_rx_byte == CHAR_NEWLINE) begin
         push_entry.cls = CLS_NEWLINE;
      end else begin
         push_entry.cls = CLS_OTHER;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/scpm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scpm_queue
   import scpm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire queue_entry_type push_entry,
   input  wire logic            pop,
   output queue_entry_type      head,
   output queue_status_type     status
);

   queue_entry_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff,  count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_LAST_SLOT) ? '0 : wr_ptr_ff + QUEUE_PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_LAST_SLOT) ? '0 : rd_ptr_ff + QUEUE_PTR_WIDTH'(1);
      end
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_COUNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold entries; payload needs no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head             = entry_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign status.count     = count_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/scpm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scpm_back
   import scpm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [15:0]      timeout_ms,
   input  wire queue_status_type q_status,
   input  wire queue_entry_type  head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic                  rsp_cmd_valid,
   output logic [7:0]            rsp_cmd_char,
   output logic [15:0]           rsp_io_number,
   output logic [15:0]           rsp_cmd_value,
   output logic [1:0]            rsp_link_state,
   output logic                  rsp_resend_request
);

   // Multiply by ten and add one decimal digit, modulo 2^16
   function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [7:0] c);
      logic [15:0] times_ten;
      times_ten = {acc[12:0], 3'b000} + {acc[14:0], 1'b0};
      return times_ten + {12'd0, c[3:0]};
   endfunction

   parse_phase_type phase_ff,   phase_in;
   logic [7:0]      cmd_char_ff, cmd_char_in;
   logic [15:0]     io_acc_ff,  io_acc_in;
   logic [15:0]     val_acc_ff, val_acc_in;
   link_state_type  link_ff,    link_in;
   logic [15:0]     elapsed_ff, elapsed_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic            done_in, resend_in;
   logic            done_ff, resend_ff;
   logic [7:0]      out_char_ff;
   logic [15:0]     out_io_ff, out_val_ff;
   link_state_type  out_link_ff;
   link_state_type  link_mid;

   // Take the head when the output register is free or being drained
   assign pop = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);

   // Carry out one transaction
   always_comb begin
      phase_in    = phase_ff;
      cmd_char_in = cmd_char_ff;
      io_acc_in   = io_acc_ff;
      val_acc_in  = val_acc_ff;
      elapsed_in  = elapsed_ff;
      link_mid    = link_ff;
      done_in     = 1'b0;
      resend_in   = 1'b0;

      if (head.cls == CLS_TICK) begin
         if (elapsed_ff != 16'hffff) begin
            elapsed_in = elapsed_ff + 16'd1;
         end
      end else begin
         unique case (phase_ff)
            PHASE_IO: begin
               if (head.cls == CLS_DIGIT) begin
                  io_acc_in = acc_digit(io_acc_ff, head.rx_byte);
               end else if (head.cls == CLS_COLON) begin
                  val_acc_in = 16'd0;
                  phase_in   = PHASE_VALUE;
               end
            end
            PHASE_VALUE: begin
               if (head.cls == CLS_DIGIT) begin
                  val_acc_in = acc_digit(val_acc_ff, head.rx_byte);
               end else if (head.cls == CLS_NEWLINE) begin
                  done_in  = 1'b1;
                  phase_in = PHASE_CMD;
                  if (cmd_char_ff == CHAR_OK || cmd_char_ff == CHAR_ENABLE) begin
                     elapsed_in = 16'd0;
                     resend_in  = (cmd_char_ff == CHAR_ENABLE) && (link_ff == LINK_LOST);
                     link_mid   = LINK_UP;
                  end
               end
            end
            default: begin
               // command phase, unused code included
               cmd_char_in = head.rx_byte;
               io_acc_in   = 16'd0;
               val_acc_in  = 16'd0;
               phase_in    = PHASE_IO;
            end
         endcase
      end

      // Watchdog update after every transaction
      link_in = link_mid;
      if (link_mid != LINK_NEVER) begin
         if (elapsed_in > timeout_ms) begin
            if (link_mid == LINK_UP) begin
               link_in = LINK_LOST;
            end
         end else begin
            link_in = LINK_UP;
         end
      end

      rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_CMD;
         cmd_char_ff  <= 8'd0;
         io_acc_ff    <= 16'd0;
         val_acc_ff   <= 16'd0;
         link_ff      <= LINK_NEVER;
         elapsed_ff   <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff    <= phase_in;
            cmd_char_ff <= cmd_char_in;
            io_acc_ff   <= io_acc_in;
            val_acc_ff  <= val_acc_in;
            link_ff     <= link_in;
            elapsed_ff  <= elapsed_in;
         end
      end
   end

   // Load the result register; the command fields read zero without a command
   always_ff @(posedge clock) begin
      if (pop) begin
         done_ff     <= done_in;
         resend_ff   <= resend_in;
         out_char_ff <= done_in ? cmd_char_ff : 8'd0;
         out_io_ff   <= done_in ? io_acc_ff   : 16'd0;
         out_val_ff  <= done_in ? val_acc_ff  : 16'd0;
         out_link_ff <= link_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cmd_valid      = done_ff;
   assign rsp_cmd_char       = out_char_ff;
   assign rsp_io_number      = out_io_ff;
   assign rsp_cmd_value      = out_val_ff;
   assign rsp_link_state     = out_link_ff;
   assign rsp_resend_request = resend_ff;

endmodule

`default_nettype wire
